// ===== rtl/nps_pkg.sv =====
// ============================================================================
// nps_pkg
// Shared sizes, payload structs and controller/datapath interface structs
// for the non-preemptive priority scheduler.
// ============================================================================
package nps_pkg;

    // Process table depth (1 to 127)
    localparam int MAX_PROCS = 64;
    // Entry index width and process-count width
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam int TIME_W = 23;

    // One process descriptor on the input channel
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic        last_item;
    } in_item_t;

    // One per-process result on the output channel
    typedef struct packed {
        logic [6:0]        proc_id;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last_result;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_en;      // input channel open
        logic addr_clear;   // rewind read address, clear scan candidates
        logic scan_issue;   // read next entry for the scan compare
        logic dispatch;     // run the picked process or jump time
        logic out_issue;    // read next entry for a result
        logic out_capture;  // form the result into the output register
        logic set_clear;    // drop the finished set
    } nps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic load_last;    // closing item transferred this cycle
        logic addr_last;    // read address is at the last held entry
        logic sched_done;   // every held process has completed
        logic out_taken;    // result transferred this cycle
        logic out_last;     // result in the output register closes the set
    } nps_status_t;

endpackage

// ===== rtl/nps_datapath.sv =====
// ============================================================================
// nps_datapath
// Process table, scan compare, simulated clock, finish times and the
// result register of the scheduler.
// ============================================================================
module nps_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  nps_pkg::nps_cmd_t cmd,
    output nps_pkg::nps_status_t status,
    input  logic              in_valid,
    input  nps_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output nps_pkg::out_item_t out_data
);
    import nps_pkg::*;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } proc_rec_t;

    // Process table and finish-time memory
    proc_rec_t         proc_mem [MAX_PROCS];
    logic [TIME_W-1:0] fin_mem  [MAX_PROCS];

    logic [MAX_PROCS-1:0] done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     completed_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 cmp_valid_reg;
    proc_rec_t            rd_rec_reg;
    logic [TIME_W-1:0]    rd_fin_reg;

    // Scan candidates: best arrived process and earliest pending arrival
    logic                 best_valid_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [7:0]           best_prio_reg;
    logic [15:0]          best_arr_reg;
    logic [15:0]          best_burst_reg;
    logic                 next_valid_reg;
    logic [15:0]          next_arr_reg;

    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 load_xfer;
    logic                 store_en;
    logic                 arrived;
    logic                 take_best;
    logic                 take_next;
    logic [TIME_W-1:0]    run_end;
    logic [TIME_W-1:0]    tat;
    logic [TIME_W-1:0]    wt;

    assign load_xfer = cmd.load_en & in_valid;
    assign store_en  = load_xfer & (count_reg < CNT_W'(MAX_PROCS));

    // Compare stage on the registered read data
    assign arrived   = (TIME_W'(rd_rec_reg.arrival) <= time_reg);
    assign take_best = cmp_valid_reg & ~done_reg[cmp_idx_reg] & arrived &
                       (~best_valid_reg ||
                        (rd_rec_reg.prio < best_prio_reg) ||
                        ((rd_rec_reg.prio == best_prio_reg) &&
                         (rd_rec_reg.arrival < best_arr_reg)));
    assign take_next = cmp_valid_reg & ~done_reg[cmp_idx_reg] & ~arrived &
                       (~next_valid_reg || (rd_rec_reg.arrival < next_arr_reg));

    assign run_end = time_reg + TIME_W'(best_burst_reg);

    // Result arithmetic
    assign tat = rd_fin_reg - TIME_W'(rd_rec_reg.arrival);
    assign wt  = tat - TIME_W'(rd_rec_reg.burst);

    // Memories: one write, registered read
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            proc_mem[count_reg[IDX_W-1:0]] <= '{arrival: in_data.arrival,
                                                burst:   in_data.burst,
                                                prio:    in_data.prio};
        end
        if (cmd.dispatch && best_valid_reg)
        begin
            fin_mem[best_idx_reg] <= run_end;
        end
        if (cmd.scan_issue || cmd.out_issue)
        begin
            rd_rec_reg <= proc_mem[addr_reg];
            rd_fin_reg <= fin_mem[addr_reg];
            cmp_idx_reg <= addr_reg;
        end
    end

    // Candidate payloads
    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_idx_reg   <= cmp_idx_reg;
            best_prio_reg  <= rd_rec_reg.prio;
            best_arr_reg   <= rd_rec_reg.arrival;
            best_burst_reg <= rd_rec_reg.burst;
        end
        if (take_next)
        begin
            next_arr_reg <= rd_rec_reg.arrival;
        end
        if (cmd.out_capture)
        begin
            out_reg.proc_id     <= 7'(cmp_idx_reg) + 7'd1;
            out_reg.finish_time <= rd_fin_reg;
            out_reg.turnaround  <= tat;
            out_reg.waiting     <= wt;
            out_reg.last_result <= (CNT_W'(cmp_idx_reg) == count_reg - CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= '0;
            count_reg      <= '0;
            completed_reg  <= '0;
            time_reg       <= '0;
            addr_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            next_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_issue;

            if (store_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            // Address walk over held entries
            if (cmd.addr_clear)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan_issue || cmd.out_issue)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end

            // Candidate flags
            if (cmd.addr_clear)
            begin
                best_valid_reg <= 1'b0;
                next_valid_reg <= 1'b0;
            end
            else
            begin
                if (take_best)
                begin
                    best_valid_reg <= 1'b1;
                end
                if (take_next)
                begin
                    next_valid_reg <= 1'b1;
                end
            end

            // Dispatch: run to completion, or jump to next arrival
            if (cmd.dispatch)
            begin
                if (best_valid_reg)
                begin
                    time_reg               <= run_end;
                    done_reg[best_idx_reg] <= 1'b1;
                    completed_reg          <= completed_reg + CNT_W'(1);
                end
                else
                begin
                    time_reg <= TIME_W'(next_arr_reg);
                end
            end

            // Result register
            if (cmd.out_capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.set_clear)
            begin
                done_reg      <= '0;
                count_reg     <= '0;
                completed_reg <= '0;
                time_reg      <= '0;
            end
        end
    end

    assign status.load_last  = load_xfer & in_data.last_item;
    assign status.addr_last  = (CNT_W'(addr_reg) == count_reg - CNT_W'(1));
    assign status.sched_done = (completed_reg == count_reg);
    assign status.out_taken  = out_valid_reg & ~out_stall;
    assign status.out_last   = out_reg.last_result;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/nps_ctrl.sv =====
// ============================================================================
// nps_ctrl
// Sequencer of the scheduler: load, scan and dispatch rounds, result
// readout and set clear.
// ============================================================================
module nps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nps_pkg::nps_status_t status,
    output nps_pkg::nps_cmd_t    cmd
);
    import nps_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DISPATCH,
        S_OUT_ISSUE,
        S_OUT_CAPTURE,
        S_OUT_HOLD,
        S_CLEAR
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (status.load_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.sched_done ? S_OUT_ISSUE : S_SCAN;
            end
            S_SCAN:
            begin
                if (status.addr_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:       state_next = S_DISPATCH;
            S_DISPATCH:    state_next = S_CHECK;
            S_OUT_ISSUE:   state_next = S_OUT_CAPTURE;
            S_OUT_CAPTURE: state_next = S_OUT_HOLD;
            S_OUT_HOLD:
            begin
                if (status.out_taken)
                begin
                    state_next = status.out_last ? S_CLEAR : S_OUT_ISSUE;
                end
            end
            S_CLEAR:       state_next = S_LOAD;
            default:       state_next = S_LOAD;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode
    always_comb
    begin
        cmd             = '0;
        cmd.load_en     = (state_reg == S_LOAD);
        cmd.addr_clear  = (state_reg == S_CHECK);
        cmd.scan_issue  = (state_reg == S_SCAN);
        cmd.dispatch    = (state_reg == S_DISPATCH);
        cmd.out_issue   = (state_reg == S_OUT_ISSUE);
        cmd.out_capture = (state_reg == S_OUT_CAPTURE);
        cmd.set_clear   = (state_reg == S_CLEAR);
    end

endmodule

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// ============================================================================
// nonpreemptive_priority_scheduler
// Loads a set of processes, schedules them non-preemptively by priority and
// returns completion, turnaround and waiting times per process in id order.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   in_item_t  (one process)
//   out      source     out_valid/out_stall out_item_t (one result)
//
// Loading can take a new item every cycle. After the closing item, each
// dispatch round reads the whole table through one memory port, at most 2n
// rounds per set of n held processes. Each result is read, captured into the
// output register and held until taken. in_stall stays high from the closing
// transfer through the cycle after the last result is taken (set clear).
// Reset clears the controller, counts, flags, time and read address only.
// ============================================================================
module nonpreemptive_priority_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nps_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output nps_pkg::out_item_t out_data
);
    import nps_pkg::*;

    nps_cmd_t    cmd;
    nps_status_t status;

    assign in_stall = ~cmd.load_en;

    nps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    nps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== tb/nps_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// nps_checker
// Watches both channels of the priority scheduler. It rebuilds each process
// set from the input transfers, schedules it when the closing item arrives,
// and checks every result transfer field by field against the oldest
// expected result.
// ============================================================================
module nps_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  nps_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  nps_pkg::out_item_t out_data,
    output int                 errors,
    output int                 pending
);

    localparam int SLOTS = nps_pkg::MAX_PROCS;

    typedef logic [nps_pkg::TIME_W-1:0] tick_t;

    // Process table of the set being loaded
    logic [15:0] arr_tab   [SLOTS];
    logic [15:0] burst_tab [SLOTS];
    logic [7:0]  prio_tab  [SLOTS];
    int          held = 0;

    nps_pkg::out_item_t expected_q [$];

    // Dispatch order: lower priority number, then earlier arrival, then lower id
    function automatic bit runs_first(int a, int b);
        if (prio_tab[a] != prio_tab[b])
            return prio_tab[a] < prio_tab[b];
        if (arr_tab[a] != arr_tab[b])
            return arr_tab[a] < arr_tab[b];
        return a < b;
    endfunction

    // Run the held set to completion and queue one result per process
    task automatic schedule_set();
        tick_t              sched_clock;
        tick_t              next_arrival;
        tick_t              finish [SLOTS];
        bit                 finished [SLOTS];
        bit                 have_next;
        int                 pick;
        int                 completed;
        nps_pkg::out_item_t res;
        sched_clock = '0;
        completed   = 0;
        for (int i = 0; i < held; i++)
            finished[i] = 1'b0;
        while (completed < held)
        begin
            pick         = -1;
            have_next    = 1'b0;
            next_arrival = '0;
            for (int i = 0; i < held; i++)
            begin
                if (!finished[i])
                begin
                    if (tick_t'(arr_tab[i]) <= sched_clock)
                    begin
                        if (pick < 0 || runs_first(i, pick))
                            pick = i;
                    end
                    else if (!have_next || tick_t'(arr_tab[i]) < next_arrival)
                    begin
                        next_arrival = tick_t'(arr_tab[i]);
                        have_next    = 1'b1;
                    end
                end
            end
            // nothing ready: idle until the next arrival
            if (pick < 0)
                sched_clock = next_arrival;
            else
            begin
                sched_clock      = sched_clock + tick_t'(burst_tab[pick]);
                finish[pick]     = sched_clock;
                finished[pick]   = 1'b1;
                completed++;
            end
        end
        // results leave in id order
        for (int i = 0; i < held; i++)
        begin
            res.proc_id     = 7'(i + 1);
            res.finish_time = finish[i];
            res.turnaround  = finish[i] - tick_t'(arr_tab[i]);
            res.waiting     = res.turnaround - tick_t'(burst_tab[i]);
            res.last_result = (i == held - 1);
            expected_q.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Transfers are sampled on the rising edge, before the block updates
    always @(posedge clk)
    begin
        nps_pkg::out_item_t want;
        if (rst_n)
        begin
            // result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ERROR result transfer: expected none, actual proc_id %0d",
                             $time, out_data.proc_id);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("proc_id", 32'(want.proc_id), 32'(out_data.proc_id));
                    check_field("finish_time", 32'(want.finish_time),
                                32'(out_data.finish_time));
                    check_field("turnaround", 32'(want.turnaround),
                                32'(out_data.turnaround));
                    check_field("waiting", 32'(want.waiting), 32'(out_data.waiting));
                    check_field("last_result", 32'(want.last_result),
                                32'(out_data.last_result));
                end
            end
            // process transfer; entries past the table depth are dropped
            if (in_valid && !in_stall)
            begin
                if (held < SLOTS)
                begin
                    arr_tab[held]   = in_data.arrival;
                    burst_tab[held] = in_data.burst;
                    prio_tab[held]  = in_data.prio;
                    held++;
                end
                if (in_data.last_item)
                begin
                    schedule_set();
                    held = 0;
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_nonpreemptive_priority_scheduler.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_nonpreemptive_priority_scheduler
// Drives process sets into the scheduler: a directed part for ties, idle
// jumps, zero bursts and field extremes, then random sets of varied shape,
// including a full table and an oversized set. Both channels idle at random.
// The checker beside the block predicts and compares every result.
// ============================================================================
module tb_nonpreemptive_priority_scheduler;

    import nps_pkg::*;

    localparam int RAND_ITEMS  = 315;
    localparam int TAIL_CYCLES = 20;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 40;

    // Content shapes for random sets
    typedef enum {
        FILL_TIGHT,     // close arrivals, short bursts, many priority ties
        FILL_SPREAD,    // moderate spacing with idle gaps
        FILL_WIDE       // full field ranges
    } fill_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    int check_errors;
    int check_pending;
    int results_taken   = 0;
    bit long_hold_done  = 1'b0;
    bit gaps_on         = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    nonpreemptive_priority_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    nps_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (check_errors),
        .pending   (check_pending)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            results_taken <= results_taken + 1;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] draw_tick(fill_t mode, bit for_burst);
        case (mode)
            FILL_TIGHT:  return 16'(for_burst ? $urandom_range(0, 15) : $urandom_range(0, 40));
            FILL_SPREAD: return 16'($urandom_range(0, for_burst ? 300 : 2000));
            default:     return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] draw_prio(fill_t mode);
        case (mode)
            FILL_TIGHT:  return 8'($urandom_range(0, 3));
            FILL_SPREAD: return 8'($urandom_range(0, 15));
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one process and hold it until the transfer completes
    task automatic send_proc(input logic [15:0] arrival, input logic [15:0] burst,
                             input logic [7:0] prio, input logic last);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= '{arrival, burst, prio, last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_set(input int size, input fill_t mode);
        for (int k = 0; k < size; k++)
            send_proc(draw_tick(mode, 1'b0), draw_tick(mode, 1'b1), draw_prio(mode),
                      k == size - 1);
    endtask

    // Sender goes quiet until every expected result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        wait (check_pending == 0);
        @(negedge clk);
    endtask

    // Result side stalls; once, a long hold backs up the input side
    initial
    begin
        int free_len;
        int stall_len;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!long_hold_done && out_valid && results_taken >= HOLD_AFTER)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end
            free_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(1, 4);
            stall_len = pick_gap();
            out_stall <= 1'b0;
            repeat (free_len) @(negedge clk);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int    sent;
        int    set_no;
        int    size;
        fill_t mode;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single process at time zero with zero burst
        send_proc(16'd0, 16'd0, 8'd0, 1'b1);
        // single process at the largest arrival and burst: time jumps ahead
        send_proc(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // equal priority and arrival: id order, zero bursts mixed in
        send_proc(16'd0, 16'd0, 8'd7, 1'b0);
        send_proc(16'd0, 16'd5, 8'd7, 1'b0);
        send_proc(16'd0, 16'd0, 8'd7, 1'b0);
        send_proc(16'd0, 16'd3, 8'd7, 1'b1);
        // priority wins over id; equal priority falls back to earlier arrival
        send_proc(16'd10, 16'd4, 8'd1, 1'b0);
        send_proc(16'd0, 16'd20, 8'd200, 1'b0);
        send_proc(16'd5, 16'd2, 8'd1, 1'b0);
        send_proc(16'd5, 16'd1, 8'd0, 1'b1);
        // idle stretches between arrivals, closing with a zero burst
        send_proc(16'd100, 16'd10, 8'd3, 1'b0);
        send_proc(16'd5000, 16'd1, 8'd3, 1'b0);
        send_proc(16'hFFFF, 16'd0, 8'd0, 1'b1);
        // priority extremes with long bursts
        send_proc(16'd0, 16'hFFFF, 8'hFF, 1'b0);
        send_proc(16'd1, 16'hFFFF, 8'd0, 1'b1);
        drain();

        // random sets: mostly small, one full table and one oversized set
        sent   = 0;
        set_no = 0;
        while (sent < RAND_ITEMS)
        begin
            set_no++;
            gaps_on = ($urandom_range(0, 3) != 0);
            if (set_no == 4)
            begin
                // full table, late arrivals and longest bursts
                for (int k = 0; k < MAX_PROCS; k++)
                    send_proc((k == 0) ? 16'hFFFF : 16'($urandom_range(60000, 65535)),
                              16'hFFFF, 8'($urandom_range(0, 255)), k == MAX_PROCS - 1);
                sent += MAX_PROCS;
            end
            else if (set_no == 10)
            begin
                // more items than the table holds; the extras are dropped
                size = MAX_PROCS + 6;
                send_random_set(size, FILL_WIDE);
                sent += size;
            end
            else
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                     : $urandom_range(1, 8);
                mode = fill_t'($urandom_range(0, 2));
                send_random_set(size, mode);
                sent += size;
            end
            if (set_no == 7)
                drain();
        end
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (check_errors == 0 && check_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nps_pkg.sv
rtl/nps_datapath.sv
rtl/nps_ctrl.sv
rtl/nonpreemptive_priority_scheduler.sv
tb/nps_checker.sv
tb/tb_nonpreemptive_priority_scheduler.sv
